@@ rtl/ttb_pkg.sv @@
// Shared types and constants of the connection timer table.
`default_nettype none

package ttb_pkg;

    // Request codes of the input word
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_ARM_TW = 2'd1;
    localparam logic [1:0] REQ_ARM_RT = 2'd2;
    localparam logic [1:0] REQ_STOP   = 2'd3;

    // Event codes of the result word
    localparam logic [1:0] EV_CLOSE   = 2'd0;
    localparam logic [1:0] EV_RETRANS = 2'd1;
    localparam logic [1:0] EV_RESET   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TICK_STEP       = 2'd0;
    localparam logic [1:0] CFG_TIMEWAIT_LENGTH = 2'd1;
    localparam logic [1:0] CFG_RETRANS_BASE    = 2'd2;
    localparam logic [1:0] CFG_RETRY_LIMIT     = 2'd3;

    localparam logic [31:0] TICK_STEP_RST       = 32'd100000;
    localparam logic [31:0] TIMEWAIT_LENGTH_RST = 32'd2000000;
    localparam logic [31:0] RETRANS_BASE_RST    = 32'd200000;
    localparam logic [2:0]  RETRY_LIMIT_RST     = 3'd3;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] slot;
    } in_word_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [3:0] slot_id;
        logic [2:0] retry_count;
        logic       last_event;
    } out_word_t;

    // One timer entry as kept in the table memory
    typedef struct packed {
        logic                is_retrans;
        logic [COUNT_W-1:0]  retries;
        logic [TIME_W-1:0]   remaining;
    } slot_word_t;

    // Outcome of one slot visit during a tick
    typedef struct packed {
        logic               hit;
        logic [1:0]         kind;
        logic [COUNT_W-1:0] count;
        logic               keep_active;
    } slot_result_t;

endpackage

`default_nettype wire

@@ rtl/ttb_timer_mem.sv @@
// Timer entry memory: one write port, one registered read port.
`default_nettype none

module ttb_timer_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire ttb_pkg::slot_word_t wdata,
    input  wire logic [AW-1:0]      raddr,
    output ttb_pkg::slot_word_t     rdata
);

    ttb_pkg::slot_word_t mem [DEPTH];
    ttb_pkg::slot_word_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/ttb_slot_alu.sv @@
// Shared per-slot unit: saturating decrement, expiry check and backoff reload.
`default_nettype none

module ttb_slot_alu (
    input  wire ttb_pkg::slot_word_t          word_in,
    input  wire logic                         active,
    input  wire logic [ttb_pkg::TIME_W-1:0]   tick_step,
    input  wire logic [ttb_pkg::TIME_W-1:0]   retrans_base,
    input  wire logic [ttb_pkg::COUNT_W-1:0]  retry_limit,
    output ttb_pkg::slot_word_t               word_out,
    output ttb_pkg::slot_result_t             result
);

    localparam int WIDE_W = ttb_pkg::TIME_W + 7;

    logic [ttb_pkg::TIME_W-1:0]  dec;
    logic [ttb_pkg::COUNT_W-1:0] cnt_inc;
    logic [WIDE_W-1:0]           wide;
    logic [ttb_pkg::TIME_W-1:0]  reload;
    logic                        expired;

    always_comb begin
        dec     = (word_in.remaining > tick_step) ? word_in.remaining - tick_step
                                                  : '0;
        expired = active && (dec == '0);
        cnt_inc = word_in.retries + ttb_pkg::COUNT_W'(1);
        wide    = WIDE_W'(retrans_base) << cnt_inc;
        // Saturate when any bit shifts past the top of the timer width
        reload  = (|wide[WIDE_W-1:ttb_pkg::TIME_W]) ? '1 : wide[ttb_pkg::TIME_W-1:0];

        word_out           = word_in;
        word_out.remaining = dec;
        result.hit         = expired;
        result.kind        = ttb_pkg::EV_CLOSE;
        result.count       = '0;
        result.keep_active = active;

        if (expired) begin
            if (!word_in.is_retrans) begin
                result.keep_active = 1'b0;
            end else if (word_in.retries < retry_limit) begin
                result.kind        = ttb_pkg::EV_RETRANS;
                result.count       = cnt_inc;
                word_out.retries   = cnt_inc;
                word_out.remaining = reload;
            end else begin
                result.kind        = ttb_pkg::EV_RESET;
                result.count       = word_in.retries;
                result.keep_active = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcp_timer_table_backoff.sv @@
// Top level of the connection timer table with retransmission backoff.
`default_nettype none

// A table of NUM_TIMERS connection timers, each a time-wait or a
// retransmission timer. Input words are requests: arm time-wait, arm
// retransmission and stop act on one slot and give no result; a slot
// number at or above NUM_TIMERS is ignored. A tick walks the table in
// ascending slot order, one slot per cycle unless the result port stalls,
// through a shared decrement/compare/shift unit, and emits one result word
// per expired timer: close for time-wait, retransmit (count raised, timer
// reloaded to retrans_base << count, saturating) or reset once the count has
// reached retry_limit. last_event marks the final word of a tick; a tick
// with no expiry gives no words. A tick occupies the block through a step
// that starts the table read, one step per slot and a step that releases
// the held-back final word, and waits while the result port stalls. The
// entries live in a single-port-write, registered-read memory, which sets
// the one-slot-per-cycle pace; the active flags are flip-flops cleared by
// reset, so no clearing pass is needed. Configuration is a plain write port
// (cfg_wr_en, cfg_addr, cfg_wdata) to be used only while the block is idle.
module tcp_timer_table_backoff #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ttb_pkg::in_word_t s_data,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output ttb_pkg::out_word_t     m_data,

    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [31:0]       cfg_wdata
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = ((IW > 4) ? IW : 4) + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PREP  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [NUM_TIMERS-1:0] active_reg, active_next;

    // One result held back until we know whether another follows it
    logic                  pend_valid_reg, pend_valid_next;
    ttb_pkg::out_word_t    pend_reg, pend_next;

    logic                  m_valid_reg, m_valid_next;
    ttb_pkg::out_word_t    m_data_reg, m_data_next;

    logic [31:0]           tick_step_reg;
    logic [31:0]           timewait_length_reg;
    logic [31:0]           retrans_base_reg;
    logic [2:0]            retry_limit_reg;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    ttb_pkg::slot_word_t   mem_wdata;
    logic [IW-1:0]         mem_raddr;
    ttb_pkg::slot_word_t   mem_rdata;

    ttb_pkg::slot_word_t   alu_word;
    ttb_pkg::slot_result_t alu_res;

    logic [CW-1:0]         slot_ext;
    logic [CW-1:0]         idx_ext;
    logic [IW-1:0]         slot_idx;
    logic                  slot_in_range;
    logic                  can_push;
    logic                  scan_stall;
    logic                  idx_last;

    ttb_timer_mem #(
        .DEPTH (NUM_TIMERS),
        .AW    (IW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ttb_slot_alu u_alu (
        .word_in      (mem_rdata),
        .active       (active_reg[idx_reg]),
        .tick_step    (tick_step_reg),
        .retrans_base (retrans_base_reg),
        .retry_limit  (retry_limit_reg),
        .word_out     (alu_word),
        .result       (alu_res)
    );

    assign slot_ext      = CW'(s_data.slot);
    assign slot_in_range = slot_ext < CW'(NUM_TIMERS);
    assign slot_idx      = slot_ext[IW-1:0];
    assign idx_ext       = CW'(idx_reg);
    assign idx_last      = idx_reg == IW'(NUM_TIMERS - 1);
    assign can_push      = !m_valid_reg || m_ready;
    // Hold the scan when a new expiry needs the pending slot and the port is full
    assign scan_stall    = alu_res.hit && pend_valid_reg && !can_push;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        active_next     = active_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = alu_word;
        mem_raddr       = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.req_type == ttb_pkg::REQ_TICK) begin
                        idx_next   = '0;
                        state_next = ST_PREP;
                    end else if (slot_in_range) begin
                        if (s_data.req_type == ttb_pkg::REQ_STOP) begin
                            active_next[slot_idx] = 1'b0;
                        end else begin
                            // Arm: overwrite the entry and restart its count
                            active_next[slot_idx] = 1'b1;
                            mem_we               = 1'b1;
                            mem_waddr            = slot_idx;
                            mem_wdata.is_retrans = s_data.req_type == ttb_pkg::REQ_ARM_RT;
                            mem_wdata.retries    = '0;
                            mem_wdata.remaining  =
                                (s_data.req_type == ttb_pkg::REQ_ARM_RT) ?
                                retrans_base_reg : timewait_length_reg;
                        end
                    end
                end
            end
            ST_PREP: begin
                // Read of slot zero is in flight
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!scan_stall) begin
                    if (active_reg[idx_reg]) begin
                        mem_we = 1'b1;
                    end
                    active_next[idx_reg] = alu_res.keep_active;
                    if (alu_res.hit) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = pend_reg;
                        end
                        pend_valid_next       = 1'b1;
                        pend_next.event_kind  = alu_res.kind;
                        pend_next.slot_id     = idx_ext[3:0];
                        pend_next.retry_count = alu_res.count;
                        pend_next.last_event  = 1'b0;
                    end
                    if (idx_last) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next  = idx_reg + IW'(1);
                        mem_raddr = idx_reg + IW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (can_push) begin
                    m_valid_next           = 1'b1;
                    m_data_next            = pend_reg;
                    m_data_next.last_event = 1'b1;
                    pend_valid_next        = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            idx_reg             <= '0;
            active_reg          <= '0;
            pend_valid_reg      <= 1'b0;
            m_valid_reg         <= 1'b0;
            tick_step_reg       <= ttb_pkg::TICK_STEP_RST;
            timewait_length_reg <= ttb_pkg::TIMEWAIT_LENGTH_RST;
            retrans_base_reg    <= ttb_pkg::RETRANS_BASE_RST;
            retry_limit_reg     <= ttb_pkg::RETRY_LIMIT_RST;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    ttb_pkg::CFG_TICK_STEP:       tick_step_reg       <= cfg_wdata;
                    ttb_pkg::CFG_TIMEWAIT_LENGTH: timewait_length_reg <= cfg_wdata;
                    ttb_pkg::CFG_RETRANS_BASE:    retrans_base_reg    <= cfg_wdata;
                    ttb_pkg::CFG_RETRY_LIMIT:     retry_limit_reg     <= cfg_wdata[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire
